// ===== rtl/ipau_pkg.sv =====
// Package for the prefix address unit: opcodes, status codes, lane types.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package ipau_pkg;
  localparam int unsigned NumLanes  = 16;
  localparam int unsigned V4Lanes   = 4;

  typedef enum logic [2:0] {
    OP_BLIT = 3'd0,
    OP_SUB  = 3'd1,
    OP_FSB  = 3'd2,
    OP_PLEN = 3'd3,
    OP_HLEN = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_BORROW   = 2'd2,
    ST_NOT_CIDR = 2'd3
  } status_t;

  // What one byte lane reports to the merge stage
  typedef struct packed {
    logic [7:0] blit;    // blit byte
    logic [7:0] diff_b0; // difference with borrow in 0
    logic [7:0] diff_b1; // difference with borrow in 1
    logic       bo_b0;   // borrow out with borrow in 0
    logic       bo_b1;   // borrow out with borrow in 1
    logic       a_nz;    // byte of A not zero
    logic [2:0] a_lz;    // leading zeros of A byte (valid when a_nz)
    logic       ne;      // A and B bytes differ
    logic [2:0] ne_lz;   // first differing bit (valid when ne)
    logic [7:0] a_ones;  // A bits that are set
    logic [7:0] b_zero;  // B bits that are clear
  } lane_res_t;
endpackage
`default_nettype wire

// ===== rtl/ipau_lane.sv =====
// One byte lane of the prefix address unit: blit, subtract and bit scans.
// Depends on ipau_pkg.
`default_nettype none
module ipau_lane (
  input  wire logic [7:0]        lane_idx,
  input  wire logic [7:0]        a_byte,
  input  wire logic [7:0]        b_byte,
  input  wire logic [7:0]        split_bits,
  input  wire logic [7:0]        prefix_and_byte,
  input  wire logic [7:0]        prefix_or_byte,
  input  wire logic [7:0]        host_and_byte,
  input  wire logic [7:0]        host_or_byte,
  output ipau_pkg::lane_res_t    res
);
  logic [8:0] base;
  logic [7:0] hm;
  logic [7:0] pm;
  logic [8:0] d0;
  logic [8:0] d1;
  logic [7:0] x;

  function automatic logic [2:0] lz8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd7;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) n = 3'(7 - k);
    end
    return n;
  endfunction

  // Build the host mask for this byte from the split point
  always_comb begin
    base = {lane_idx, 3'd0} > 11'd255 ? 9'd0 : {lane_idx[5:0], 3'd0};
    if (base + 9'd8 <= {1'b0, split_bits}) hm = 8'h00;
    else if (base >= {1'b0, split_bits}) hm = 8'hFF;
    else hm = 8'hFF >> split_bits[2:0];
    pm = ~hm;
  end

  assign d0 = {1'b0, a_byte} - {1'b0, b_byte};
  assign d1 = {1'b0, a_byte} - {1'b0, b_byte} - 9'd1;
  assign x  = a_byte ^ b_byte;

  always_comb begin
    res.blit    = (a_byte & ((prefix_and_byte & pm) | (host_and_byte & hm)))
                  | ((prefix_or_byte & pm) | (host_or_byte & hm));
    res.diff_b0 = d0[7:0];
    res.diff_b1 = d1[7:0];
    res.bo_b0   = d0[8];
    res.bo_b1   = d1[8];
    res.a_nz    = |a_byte;
    res.a_lz    = lz8(a_byte);
    res.ne      = |x;
    res.ne_lz   = lz8(x);
    res.a_ones  = a_byte;
    res.b_zero  = ~b_byte;
  end
endmodule
`default_nettype wire

// ===== rtl/ipau_merge.sv =====
// Merge stage: combines lane reports into the result fields for one transfer.
// Depends on ipau_pkg.
`default_nettype none
module ipau_merge (
  input  wire logic [2:0]             opcode,
  input  wire logic                   is_ipv6,
  input  wire logic [7:0]             split_bits,
  input  wire logic [127:0]           a_all,
  input  wire ipau_pkg::lane_res_t    lanes [ipau_pkg::NumLanes],
  output logic [127:0]                result,
  output logic [7:0]                  bit_count,
  output logic [1:0]                  status
);
  logic [7:0]   width;
  logic [127:0] blit_v;
  logic [127:0] sub_v;
  logic         borrow;
  logic [7:0]   fsb;
  logic [7:0]   pfx;
  logic         found_a;
  logic         found_d;
  logic [127:0] host_m;
  logic [127:0] a_ones;
  logic [127:0] b_zero;
  logic         cidr_ok;
  logic [7:0]   pidx;

  assign width = is_ipv6 ? 8'd128 : 8'd32;

  // Ripple the borrow lane to lane, select precomputed differences and blit bytes
  always_comb begin
    borrow = 1'b0;
    sub_v  = '0;
    blit_v = a_all;
    for (int i = ipau_pkg::NumLanes - 1; i >= 0; i--) begin
      if (is_ipv6 || i < ipau_pkg::V4Lanes) begin
        sub_v[127 - 8*i -: 8]  = borrow ? lanes[i].diff_b1 : lanes[i].diff_b0;
        blit_v[127 - 8*i -: 8] = lanes[i].blit;
        borrow = borrow ? lanes[i].bo_b1 : lanes[i].bo_b0;
      end
    end
  end

  // Priority pick of the first set bit and first differing bit
  always_comb begin
    fsb = width;
    pfx = width;
    found_a = 1'b0;
    found_d = 1'b0;
    for (int i = 0; i < ipau_pkg::NumLanes; i++) begin
      if (is_ipv6 || i < ipau_pkg::V4Lanes) begin
        if (!found_a && lanes[i].a_nz) begin
          fsb = 8'({i[4:0], lanes[i].a_lz});
          found_a = 1'b1;
        end
        if (!found_d && lanes[i].ne) begin
          pfx = 8'({i[4:0], lanes[i].ne_lz});
          found_d = 1'b1;
        end
      end
    end
  end

  // Host part must be zero in A and all ones in B
  always_comb begin
    a_ones = '0;
    b_zero = '0;
    for (int i = 0; i < ipau_pkg::NumLanes; i++) begin
      a_ones[127 - 8*i -: 8] = lanes[i].a_ones;
      b_zero[127 - 8*i -: 8] = lanes[i].b_zero;
    end
    pidx   = pfx;
    host_m = (pidx[7] ? 128'd0 : ({128{1'b1}} >> pidx[6:0]))
             & (is_ipv6 ? {128{1'b1}} : {{32{1'b1}}, 96'd0});
    cidr_ok = ~|((a_ones | b_zero) & host_m);
  end

  always_comb begin
    result = '0;
    bit_count = '0;
    status = ipau_pkg::ST_OK;
    unique case (opcode) inside
      ipau_pkg::OP_BLIT: begin
        if (split_bits > width) status = ipau_pkg::ST_TOO_LONG;
        else result = blit_v;
      end
      ipau_pkg::OP_SUB: begin
        result = sub_v;
        if (borrow) status = ipau_pkg::ST_BORROW;
      end
      ipau_pkg::OP_FSB: bit_count = fsb;
      ipau_pkg::OP_PLEN, ipau_pkg::OP_HLEN: begin
        if (!cidr_ok) status = ipau_pkg::ST_NOT_CIDR;
        else if (opcode == ipau_pkg::OP_PLEN) bit_count = pfx;
        else bit_count = width - pfx;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/ip_prefix_address_unit.sv =====
// Top level of the prefix address unit: sixteen byte lanes, merge, output skid.
// Depends on ipau_pkg, ipau_lane and ipau_merge.
// One transfer per clock while the skid entry is empty: each item is decoded
// by sixteen byte lanes and the merge stage in the same cycle and lands in a
// two-entry output register, so the input stays ready while the output stalls
// for one item; throughput is one item per cycle when out_ready is held high.
`default_nettype none
module ip_prefix_address_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic        in_is_ipv6,
  input  wire logic [63:0] in_a_upper,
  input  wire logic [63:0] in_a_lower,
  input  wire logic [63:0] in_b_upper,
  input  wire logic [63:0] in_b_lower,
  input  wire logic [7:0]  in_prefix_and_byte,
  input  wire logic [7:0]  in_prefix_or_byte,
  input  wire logic [7:0]  in_host_and_byte,
  input  wire logic [7:0]  in_host_or_byte,
  input  wire logic [7:0]  in_split_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result_upper,
  output logic [63:0]      out_result_lower,
  output logic [7:0]       out_bit_count,
  output logic [1:0]       out_status
);
  typedef struct packed {
    logic [127:0] result;
    logic [7:0]   bit_count;
    logic [1:0]   status;
  } res_t;

  logic [127:0]        a_all;
  logic [127:0]        b_all;
  ipau_pkg::lane_res_t lanes [ipau_pkg::NumLanes];
  res_t                res_c;
  res_t                main_r;
  res_t                skid_r;
  logic                main_vld_r;
  logic                skid_vld_r;
  logic                in_xfer;
  logic                out_xfer;

  assign a_all = {in_a_upper, in_a_lower};
  assign b_all = {in_b_upper, in_b_lower};

  // Byte lanes
  for (genvar g = 0; g < ipau_pkg::NumLanes; g++) begin : g_lane
    ipau_lane u_lane (
      .lane_idx        (8'(g)),
      .a_byte          (a_all[127 - 8*g -: 8]),
      .b_byte          (b_all[127 - 8*g -: 8]),
      .split_bits      (in_split_bits),
      .prefix_and_byte (in_prefix_and_byte),
      .prefix_or_byte  (in_prefix_or_byte),
      .host_and_byte   (in_host_and_byte),
      .host_or_byte    (in_host_or_byte),
      .res             (lanes[g])
    );
  end

  ipau_merge u_merge (
    .opcode     (in_opcode),
    .is_ipv6    (in_is_ipv6),
    .split_bits (in_split_bits),
    .a_all      (a_all),
    .lanes      (lanes),
    .result     (res_c.result),
    .bit_count  (res_c.bit_count),
    .status     (res_c.status)
  );

  assign in_ready = !skid_vld_r;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = main_vld_r && out_ready;

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (out_xfer || !main_vld_r) begin
        if (skid_vld_r) begin
          main_r     <= skid_r;
          main_vld_r <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          main_r     <= res_c;
          main_vld_r <= in_xfer;
        end
      end else if (in_xfer) begin
        skid_r     <= res_c;
        skid_vld_r <= 1'b1;
      end
    end
  end

  assign out_valid        = main_vld_r;
  assign out_result_upper = main_r.result[127:64];
  assign out_result_lower = main_r.result[63:0];
  assign out_bit_count    = main_r.bit_count;
  assign out_status       = main_r.status;

`ifndef SYNTH
  // Skid holds data only behind a full main register
  a_skid_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r) else $error("skid full with main empty");
  // A stalled output keeps its result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(main_r)))
    else $error("output changed under stall");
  // Bit count never exceeds 128, the IPv6 address width
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bit_count <= 8'd128) else $error("bit count too large");
`endif
endmodule
`default_nettype wire
